// ===== rtl/fbc_pkg.sv =====
// Shared types and constants for the frustum box cull core.
package fbc_pkg;

   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int REG_W      = 64;
   localparam int ENTRY_W    = 32;
   localparam int NUM_PLANES = 6;
   localparam int NUM_AXES   = 3;
   // plane terms are a sum or difference of two matrix entries
   localparam int TERM_W     = ENTRY_W + 1;

   // matrix entry [column][row], signed fixed point
   typedef logic [ENTRY_W-1:0] mat_entry_type;
   typedef mat_entry_type [3:0][3:0] mat_type;

   // register names in index order
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COL0_ROWS01 = 3'd0,
      REG_COL0_ROWS23 = 3'd1,
      REG_COL1_ROWS01 = 3'd2,
      REG_COL1_ROWS23 = 3'd3,
      REG_COL2_ROWS01 = 3'd4,
      REG_COL2_ROWS23 = 3'd5,
      REG_COL3_ROWS01 = 3'd6,
      REG_COL3_ROWS23 = 3'd7
   } csr_reg_type;

   localparam logic [REG_W-1:0] RESET_COL0_ROWS01 = 64'h0000_0000_0001_0000;
   localparam logic [REG_W-1:0] RESET_COL0_ROWS23 = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RESET_COL1_ROWS01 = 64'h0001_0000_0000_0000;
   localparam logic [REG_W-1:0] RESET_COL1_ROWS23 = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RESET_COL2_ROWS01 = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RESET_COL2_ROWS23 = 64'h0000_0000_0001_0000;
   localparam logic [REG_W-1:0] RESET_COL3_ROWS01 = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] RESET_COL3_ROWS23 = 64'h0001_0000_0000_0000;

endpackage

// ===== rtl/fbc_plane_cell.sv =====
// One plane cell of the cull chain: plane setup, corner products, signed distance test.
module fbc_plane_cell #(
   parameter int PLANE       = 0,
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  fbc_pkg::mat_type                           mat,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic [fbc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] in_lo,
   input  logic [fbc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] in_hi,
   input  logic                                       in_vis,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output logic [fbc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] out_lo,
   output logic [fbc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] out_hi,
   output logic                                       out_vis
);
   import fbc_pkg::*;

   localparam int ROW_SEL = PLANE / 2;
   localparam bit MINUS   = (PLANE % 2) != 0;
   localparam int PROD_W  = TERM_W + COORD_WIDTH;
   localparam int WIDE_W  = (COORD_WIDTH > FRAC_BITS) ? COORD_WIDTH : FRAC_BITS;
   localparam int SUM_W   = WIDE_W + TERM_W + 2;

   // plane coefficients, refreshed from the matrix every cycle
   logic [NUM_AXES-1:0][TERM_W-1:0] normal_ff, normal_in;
   logic [TERM_W-1:0]               offset_ff, offset_in;
   logic                            zero_ff, zero_in;

   // stage 1: corner products
   logic                              s1_valid_ff, s1_valid_in;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0] s1_lo_ff, s1_hi_ff;
   logic                              s1_vis_ff, s1_zero_ff;
   logic [NUM_AXES-1:0][PROD_W-1:0]   s1_prod_ff, s1_prod_in;
   logic [SUM_W-1:0]                  s1_off_ff, s1_off_in;

   // stage 2: distance sign
   logic                              s2_valid_ff, s2_valid_in;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0] s2_lo_ff, s2_hi_ff;
   logic                              s2_vis_ff, s2_vis_in;

   logic                              s1_ready, s2_ready;
   logic [SUM_W-1:0]                  dist_sum;

   always_comb begin
      logic [TERM_W-1:0] a, b;
      for (int i = 0; i < NUM_AXES; i++) begin
         a = {mat[i][3][ENTRY_W-1], mat[i][3]};
         b = {mat[i][ROW_SEL][ENTRY_W-1], mat[i][ROW_SEL]};
         normal_in[i] = MINUS ? (a - b) : (a + b);
      end
      a = {mat[3][3][ENTRY_W-1], mat[3][3]};
      b = {mat[3][ROW_SEL][ENTRY_W-1], mat[3][ROW_SEL]};
      offset_in = MINUS ? (a - b) : (a + b);
      zero_in = (normal_in == '0);
   end

   always_ff @(posedge clock) begin
      normal_ff <= normal_in;
      offset_ff <= offset_in;
      zero_ff   <= zero_in;
   end

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // take the corner farthest along the normal, one axis at a time
   always_comb begin
      logic [COORD_WIDTH-1:0] corner;
      logic [TERM_W-1:0]      n;
      for (int i = 0; i < NUM_AXES; i++) begin
         n = normal_ff[i];
         corner = (!n[TERM_W-1] && (n != '0)) ? in_hi[i] : in_lo[i];
         s1_prod_in[i] = PROD_W'($signed({{COORD_WIDTH{n[TERM_W-1]}}, n})
                        * $signed({{TERM_W{corner[COORD_WIDTH-1]}}, corner}));
      end
      s1_off_in = {{(SUM_W-TERM_W-FRAC_BITS){offset_ff[TERM_W-1]}}, offset_ff,
                   {FRAC_BITS{1'b0}}};
   end

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;

   always_comb begin
      dist_sum = s1_off_ff;
      for (int i = 0; i < NUM_AXES; i++) begin
         dist_sum = dist_sum + {{(SUM_W-PROD_W){s1_prod_ff[i][PROD_W-1]}}, s1_prod_ff[i]};
      end
   end

   // a zero normal never culls
   assign s2_vis_in   = s1_vis_ff && (s1_zero_ff || !dist_sum[SUM_W-1]);
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_lo_ff   <= in_lo;
         s1_hi_ff   <= in_hi;
         s1_vis_ff  <= in_vis;
         s1_zero_ff <= zero_ff;
         s1_prod_ff <= s1_prod_in;
         s1_off_ff  <= s1_off_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_lo_ff  <= s1_lo_ff;
         s2_hi_ff  <= s1_hi_ff;
         s2_vis_ff <= s2_vis_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_lo    = s2_lo_ff;
   assign out_hi    = s2_hi_ff;
   assign out_vis   = s2_vis_ff;

endmodule

// ===== rtl/frustum_box_cull_core.sv =====
// Top level of the frustum box cull core: matrix registers and the chain of plane cells.
//
// Tests one axis-aligned box per item against the six view-frustum planes taken
// from a 4x4 view-projection matrix (row 3 plus or minus rows 0, 1, 2) and
// returns visible = 0 when the box lies wholly behind any plane. The matrix sits
// in eight 64-bit registers written through the csr_ port, two Q16.16 entries
// each; write them only while no item is in flight. Each cell registers its plane
// terms from the matrix, so req_ready is held low after reset and
// after every register write while those terms settle. Boxes flow through a row of
// six plane cells, one per plane, each with a multiply stage and a sum-and-sign
// stage, so one item is taken per clock unless a stall or the settle hold blocks
// it; the twelve register stages (two per cell) lie between the accepting edge
// and rsp_valid.
// Every stage has its own valid bit and ready moves back along the row, so a
// stalled result backs up only as far as needed and bubbles close up. All sums
// are exact; a plane whose normal is zero never culls, and an inverted box is
// used as given. Coordinates use their low COORD_WIDTH bits, sign extended.
module frustum_box_cull_core #(
   parameter int FRAC_BITS   = 16,
   parameter int COORD_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [31:0]               req_min_x,
   input  logic signed [31:0]               req_min_y,
   input  logic signed [31:0]               req_min_z,
   input  logic signed [31:0]               req_max_x,
   input  logic signed [31:0]               req_max_y,
   input  logic signed [31:0]               req_max_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_visible,
   input  logic                             csr_wr_en,
   input  logic [fbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbc_pkg::REG_W-1:0]        csr_wdata
);
   import fbc_pkg::*;

   logic [NUM_REGS-1:0][REG_W-1:0] mat_reg_ff;
   mat_type                        mat;
   logic                           cfg_hold_ff, cfg_hold_in;

   logic                                 chain_valid [NUM_PLANES+1];
   logic                                 chain_ready [NUM_PLANES+1];
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0] chain_lo    [NUM_PLANES+1];
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0] chain_hi    [NUM_PLANES+1];
   logic                                 chain_vis   [NUM_PLANES+1];

   // Matrix registers; every index of the port maps to a register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_reg_ff[REG_COL0_ROWS01] <= RESET_COL0_ROWS01;
         mat_reg_ff[REG_COL0_ROWS23] <= RESET_COL0_ROWS23;
         mat_reg_ff[REG_COL1_ROWS01] <= RESET_COL1_ROWS01;
         mat_reg_ff[REG_COL1_ROWS23] <= RESET_COL1_ROWS23;
         mat_reg_ff[REG_COL2_ROWS01] <= RESET_COL2_ROWS01;
         mat_reg_ff[REG_COL2_ROWS23] <= RESET_COL2_ROWS23;
         mat_reg_ff[REG_COL3_ROWS01] <= RESET_COL3_ROWS01;
         mat_reg_ff[REG_COL3_ROWS23] <= RESET_COL3_ROWS23;
      end else if (csr_wr_en) begin
         mat_reg_ff[csr_index] <= csr_wdata;
      end
   end

   // Hold off input after reset or a write so the cells'
   // registered plane terms catch up with the matrix.
   assign cfg_hold_in = csr_wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_hold_ff <= 1'b1;
      end else begin
         cfg_hold_ff <= cfg_hold_in;
      end
   end

   // Unpack registers into matrix entries: even rows low half, odd rows high half.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            mat[c][r] = mat_reg_ff[c*2 + r/2][(r%2)*ENTRY_W +: ENTRY_W];
         end
      end
   end

   // Feed the head of the chain; drop coordinate bits above COORD_WIDTH.
   assign chain_valid[0] = req_valid && !cfg_hold_ff;
   assign req_ready      = chain_ready[0] && !cfg_hold_ff;
   assign chain_vis[0]   = 1'b1;
   assign chain_lo[0][0] = req_min_x[COORD_WIDTH-1:0];
   assign chain_lo[0][1] = req_min_y[COORD_WIDTH-1:0];
   assign chain_lo[0][2] = req_min_z[COORD_WIDTH-1:0];
   assign chain_hi[0][0] = req_max_x[COORD_WIDTH-1:0];
   assign chain_hi[0][1] = req_max_y[COORD_WIDTH-1:0];
   assign chain_hi[0][2] = req_max_z[COORD_WIDTH-1:0];

   // One cell per plane: left, right, bottom, top, near, far.
   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
      fbc_plane_cell #(
         .PLANE       (p),
         .COORD_WIDTH (COORD_WIDTH),
         .FRAC_BITS   (FRAC_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .mat       (mat),
         .in_valid  (chain_valid[p]),
         .in_ready  (chain_ready[p]),
         .in_lo     (chain_lo[p]),
         .in_hi     (chain_hi[p]),
         .in_vis    (chain_vis[p]),
         .out_valid (chain_valid[p+1]),
         .out_ready (chain_ready[p+1]),
         .out_lo    (chain_lo[p+1]),
         .out_hi    (chain_hi[p+1]),
         .out_vis   (chain_vis[p+1])
      );
   end

   // The last cell's output stage is the result register.
   assign rsp_valid                = chain_valid[NUM_PLANES];
   assign chain_ready[NUM_PLANES]  = rsp_ready;
   assign rsp_visible              = chain_vis[NUM_PLANES];

endmodule

// ===== tb/cull_tb_pkg.sv =====
`timescale 1ns / 1ps
// Box type, core settings and the visibility scoreboard for the frustum cull bench.
package cull_tb_pkg;

   import fbc_pkg::*;

   localparam int CULL_FRAC_BITS   = 16;
   localparam int CULL_COORD_WIDTH = 32;
   localparam int MAX_PRINTED      = 40;

   typedef struct packed {
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] min_z;
      logic signed [31:0] max_x;
      logic signed [31:0] max_y;
      logic signed [31:0] max_z;
   } box_type;

   class visibility_scoreboard;
      logic [REG_W-1:0] matrix_regs [NUM_REGS];
      logic             pending_visible [$];
      int unsigned      error_count;

      function new();
         matrix_regs[REG_COL0_ROWS01] = RESET_COL0_ROWS01;
         matrix_regs[REG_COL0_ROWS23] = RESET_COL0_ROWS23;
         matrix_regs[REG_COL1_ROWS01] = RESET_COL1_ROWS01;
         matrix_regs[REG_COL1_ROWS23] = RESET_COL1_ROWS23;
         matrix_regs[REG_COL2_ROWS01] = RESET_COL2_ROWS01;
         matrix_regs[REG_COL2_ROWS23] = RESET_COL2_ROWS23;
         matrix_regs[REG_COL3_ROWS01] = RESET_COL3_ROWS01;
         matrix_regs[REG_COL3_ROWS23] = RESET_COL3_ROWS23;
         error_count = 0;
      endfunction

      function void set_reg(csr_reg_type id, logic [REG_W-1:0] value);
         matrix_regs[id] = value;
      endfunction

      function int unsigned outstanding();
         return pending_visible.size();
      endfunction

      // entry at column col, row row: even rows in the low half
      function logic signed [ENTRY_W-1:0] entry(int col, int row);
         logic [REG_W-1:0] r;
         r = matrix_regs[col * 2 + row / 2];
         return (row % 2 == 1) ? r[63:32] : r[31:0];
      endfunction

      // keep the low COORD_WIDTH bits, sign extended
      function logic signed [31:0] narrow(logic [31:0] raw);
         logic signed [31:0] t;
         t = raw << (32 - CULL_COORD_WIDTH);
         return t >>> (32 - CULL_COORD_WIDTH);
      endfunction

      function logic predict_visible(box_type b);
         logic signed [127:0] lo_c [3];
         logic signed [127:0] hi_c [3];
         logic signed [127:0] n [3];
         logic signed [127:0] a, e, d, acc;
         int    p, i, ri;
         logic  vis;
         lo_c[0] = narrow(b.min_x);
         lo_c[1] = narrow(b.min_y);
         lo_c[2] = narrow(b.min_z);
         hi_c[0] = narrow(b.max_x);
         hi_c[1] = narrow(b.max_y);
         hi_c[2] = narrow(b.max_z);
         vis = 1'b1;
         for (p = 0; p < NUM_PLANES; p++) begin
            ri = p / 2;
            for (i = 0; i < NUM_AXES; i++) begin
               a = entry(i, 3);
               e = entry(i, ri);
               n[i] = (p % 2 == 1) ? a - e : a + e;
            end
            a = entry(3, 3);
            e = entry(3, ri);
            d = (p % 2 == 1) ? a - e : a + e;
            // a plane with no normal never culls, whatever its offset
            if (n[0] == 0 && n[1] == 0 && n[2] == 0)
               continue;
            acc = d <<< CULL_FRAC_BITS;
            for (i = 0; i < NUM_AXES; i++)
               acc = acc + n[i] * ((n[i] > 0) ? hi_c[i] : lo_c[i]);
            if (acc < 0)
               vis = 1'b0;
         end
         return vis;
      endfunction

      function void note_box(box_type b);
         pending_visible.push_back(predict_visible(b));
      endfunction

      task report_mismatch(string msg);
         if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
         error_count++;
      endtask

      task check_visible(logic got);
         logic want;
         if (pending_visible.size() == 0) begin
            report_mismatch($sformatf("result visible=%b with no box pending", got));
         end else begin
            want = pending_visible.pop_front();
            if (got !== want)
               report_mismatch($sformatf("visible got %b, want %b", got, want));
         end
      endtask
   endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the frustum box cull bench: clock, reset, box and matrix drivers, checks.
module tb_top;

   import fbc_pkg::*;
   import cull_tb_pkg::*;

   localparam int          IDLE_PCT     = 14;
   localparam int          CYCLE_LIMIT  = 200000;
   // pipeline depth plus margin; used only before matrix writes and at the end
   localparam int          SETTLE_WAIT  = 20;
   localparam int          PHASE_ITEMS  = 100;
   localparam int          NUM_PHASES   = 9;
   localparam logic [31:0] ONE          = 32'h0001_0000;
   localparam logic [31:0] LSB          = 32'h0000_0001;
   localparam logic [31:0] MOST_POS     = 32'h7FFF_FFFF;
   localparam logic [31:0] MOST_NEG     = 32'h8000_0000;

   typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_image_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_min_x = '0;
   logic signed [31:0] req_min_y = '0;
   logic signed [31:0] req_min_z = '0;
   logic signed [31:0] req_max_x = '0;
   logic signed [31:0] req_max_y = '0;
   logic signed [31:0] req_max_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_visible;
   logic               csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]   csr_wdata = '0;

   // idling on both sides is switched off for one long stretch
   logic               idling_on = 1'b1;
   int unsigned        cycle_count = 0;
   visibility_scoreboard sb;

   frustum_box_cull_core #(
      .FRAC_BITS   (CULL_FRAC_BITS),
      .COORD_WIDTH (CULL_COORD_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_min_x   (req_min_x),
      .req_min_y   (req_min_y),
      .req_min_z   (req_min_z),
      .req_max_x   (req_max_x),
      .req_max_y   (req_max_y),
      .req_max_z   (req_max_z),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_visible (rsp_visible),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // Stall the result side at random while idling is on.
   always @(posedge clock) begin
      rsp_ready <= idling_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
   end

   // Check every accepted result against the oldest predicted visibility.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_visible(rsp_visible);
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Present one box, hold it until accepted, then note it for prediction.
   // Valid is left high on return; the next call or a drain decides its fate.
   task automatic send_box(input box_type b);
      while (idling_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_min_x <= b.min_x;
      req_min_y <= b.min_y;
      req_min_z <= b.min_z;
      req_max_x <= b.max_x;
      req_max_y <= b.max_y;
      req_max_z <= b.max_z;
      do @(posedge clock); while (!req_ready);
      sb.note_box(b);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0)
         @(posedge clock);
   endtask

   // Write all eight matrix registers while the core is idle.
   task automatic load_matrix(input matrix_image_type image);
      csr_reg_type reg_id;
      drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      reg_id = REG_COL0_ROWS01;
      repeat (NUM_REGS) begin
         csr_wr_en <= 1'b1;
         csr_index <= reg_id;
         csr_wdata <= image[reg_id];
         @(posedge clock);
         sb.set_reg(reg_id, image[reg_id]);
         reg_id = reg_id.next();
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic box_type make_box(input logic [31:0] nx, ny, nz, xx, xy, xz);
      box_type b;
      b.min_x = nx;
      b.min_y = ny;
      b.min_z = nz;
      b.max_x = xx;
      b.max_y = xy;
      b.max_z = xz;
      return b;
   endfunction

   // A plausible scene box: low corner within +-8.0, sides up to 4.0.
   function automatic box_type scene_box();
      box_type b;
      b.min_x = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      b.min_y = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      b.min_z = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      b.max_x = b.min_x + $urandom_range(0, 32'h0004_0000);
      b.max_y = b.min_y + $urandom_range(0, 32'h0004_0000);
      b.max_z = b.min_z + $urandom_range(0, 32'h0004_0000);
      return b;
   endfunction

   // Mix: mostly scene boxes, some inverted, some full-range noise.
   function automatic box_type random_box();
      box_type b;
      int unsigned pick;
      pick = $urandom_range(99);
      b = scene_box();
      if (pick >= 85) begin
         b = make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick >= 70) begin
         b = make_box(b.max_x, b.max_y, b.max_z, b.min_x, b.min_y, b.min_z);
      end
      return b;
   endfunction

   // Entries within +-4.0, about one in six zero.
   function automatic logic [31:0] small_entry();
      if ($urandom_range(5) == 0)
         return '0;
      return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
   endfunction

   function automatic matrix_image_type small_matrix();
      matrix_image_type m;
      for (int k = 0; k < NUM_REGS; k++)
         m[k] = {small_entry(), small_entry()};
      return m;
   endfunction

   function automatic matrix_image_type full_matrix();
      matrix_image_type m;
      for (int k = 0; k < NUM_REGS; k++)
         m[k] = {$urandom, $urandom};
      return m;
   endfunction

   function automatic matrix_image_type fill_matrix(input logic [31:0] v);
      matrix_image_type m;
      for (int k = 0; k < NUM_REGS; k++)
         m[k] = {v, v};
      return m;
   endfunction

   function automatic matrix_image_type reset_matrix();
      matrix_image_type m;
      m[REG_COL0_ROWS01] = RESET_COL0_ROWS01;
      m[REG_COL0_ROWS23] = RESET_COL0_ROWS23;
      m[REG_COL1_ROWS01] = RESET_COL1_ROWS01;
      m[REG_COL1_ROWS23] = RESET_COL1_ROWS23;
      m[REG_COL2_ROWS01] = RESET_COL2_ROWS01;
      m[REG_COL2_ROWS23] = RESET_COL2_ROWS23;
      m[REG_COL3_ROWS01] = RESET_COL3_ROWS01;
      m[REG_COL3_ROWS23] = RESET_COL3_ROWS23;
      return m;
   endfunction

   initial begin
      matrix_image_type image;
      logic [31:0]      half;
      sb = new();
      half = ONE >> 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset matrix: visible exactly when the box overlaps [-1, 1] on every axis.
      send_box(make_box(-half, -half, -half, half, half, half));
      send_box(make_box(-ONE - ONE, '0, '0, -ONE, '0, '0));          // touches left
      send_box(make_box(-ONE - ONE, '0, '0, -ONE - LSB, '0, '0));    // just past left
      send_box(make_box(ONE, '0, '0, ONE + ONE, '0, '0));            // touches right
      send_box(make_box(ONE + LSB, '0, '0, ONE + ONE, '0, '0));      // just past right
      send_box(make_box('0, -ONE - ONE, '0, '0, -ONE, '0));          // touches bottom
      send_box(make_box('0, -ONE - ONE, '0, '0, -ONE - LSB, '0));    // just past bottom
      send_box(make_box('0, ONE, '0, '0, ONE + ONE, '0));            // touches top
      send_box(make_box('0, ONE + LSB, '0, '0, ONE + ONE, '0));      // just past top
      send_box(make_box('0, '0, -ONE - ONE, '0, '0, -ONE));          // touches near
      send_box(make_box('0, '0, -ONE - ONE, '0, '0, -ONE - LSB));    // just past near
      send_box(make_box('0, '0, ONE, '0, '0, ONE + ONE));            // touches far
      send_box(make_box('0, '0, ONE + LSB, '0, '0, ONE + ONE));      // just past far
      send_box(make_box('0, '0, '0, '0, '0, '0));                    // zero-size box
      send_box(make_box(MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS));
      send_box(make_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG));
      send_box(make_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS));
      // inverted boxes are used as given, no swap
      send_box(make_box(MOST_POS, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG));
      send_box(make_box(ONE + ONE, '0, '0, -ONE - ONE, '0, '0));

      // Zero normal: row 3 equals row 0 in columns 0..2, so the w - x plane has no
      // normal while its offset is -6.0; it must not cull.
      image = fill_matrix('0);
      image[REG_COL0_ROWS01] = {32'h0, ONE};
      image[REG_COL0_ROWS23] = {ONE, 32'h0};
      image[REG_COL3_ROWS01] = {32'h0, 32'h0005_0000};
      image[REG_COL3_ROWS23] = {-ONE, 32'h0};
      load_matrix(image);
      send_box(make_box('0, '0, '0, ONE, '0, '0));
      send_box(make_box('0, '0, '0, ONE - LSB, '0, '0));
      send_box(make_box(MOST_NEG, '0, '0, MOST_POS, '0, '0));
      send_box(make_box(MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS));

      // Random part: one matrix setting per phase, the extremes among them.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: image = reset_matrix();
            2: image = fill_matrix(MOST_POS);
            4: image = fill_matrix(MOST_NEG);
            5: image = full_matrix();
            6: image = fill_matrix('0);
            7: image = fill_matrix('1);
            default: image = small_matrix();
         endcase
         load_matrix(image);
         // long stretch with no idling on either side
         idling_on = (phase != 3);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // hold off the sender until the core has emptied, once
            if (phase == 5 && k == PHASE_ITEMS / 2)
               drain();
            send_box(random_box());
         end
      end
      idling_on = 1'b1;

      drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (sb.error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
